// File: sv/tsspc_pkg.sv
// ----------------------------------------------------------------------------
// tsspc_pkg
// Shared types, graph tables and helper functions for the thick-slice
// simple-point check.
// ----------------------------------------------------------------------------
`default_nettype none

package tsspc_pkg;

   localparam int NODE_COUNT = 17;
   localparam int RULE_COUNT = 13;
   localparam int STEP_COUNT = NODE_COUNT;
   localparam int CAUSE_W    = 3;

   localparam logic [NODE_COUNT-1:0] ALL_NODES = 17'h1ffff;

   // first rule of the second widening stage
   localparam int RULE_SPLIT = 7;

   typedef logic [NODE_COUNT-1:0] node_mask_type;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_NONE        = 3'd0,
      CAUSE_EMPTY_SET   = 3'd1,
      CAUSE_SPLIT_SET   = 3'd2,
      CAUSE_EMPTY_COMPL = 3'd3,
      CAUSE_SPLIT_COMPL = 3'd4
   } cause_type;

   // one beat travelling down the cell chain
   typedef struct packed {
      logic          valid;
      node_mask_type set;
      node_mask_type compl_set;
      node_mask_type reach_set;
      node_mask_type reach_compl;
   } beat_type;

   // neighbor lists: ring 0..7 and grid 8..16, 4-adjacency plus ring-grid twins
   localparam node_mask_type ADJ_MASK [NODE_COUNT] = '{
      17'h0010A, 17'h00205, 17'h00412, 17'h00821, 17'h02084, 17'h04048,
      17'h080A0, 17'h10050, 17'h00A01, 17'h01502, 17'h02204, 17'h05108,
      17'h0AA00, 17'h11410, 17'h08820, 17'h15040, 17'h0A080
   };

   // vertex-connectivity widening rules, in order of application
   localparam logic [4:0] RULE_TRIGGER [RULE_COUNT] = '{
      5'd1, 5'd3, 5'd4, 5'd6, 5'd12, 5'd0, 5'd2, 5'd5, 5'd7, 5'd9, 5'd11,
      5'd13, 5'd15
   };

   localparam node_mask_type RULE_ADD [RULE_COUNT] = '{
      17'h00205, 17'h00821, 17'h02084, 17'h080A0, 17'h0AA00, 17'h00100,
      17'h00400, 17'h04000, 17'h10000, 17'h00500, 17'h04100, 17'h10400,
      17'h14000
   };

   // apply rules first..last in order, each seeing the bits of those before
   function automatic node_mask_type widen_rules(node_mask_type m, int first, int last);
      node_mask_type w;
      w = m;
      for (int r = 0; r < RULE_COUNT; r++) begin
         if (r >= first && r <= last && w[RULE_TRIGGER[r]]) begin
            w = w | RULE_ADD[r];
         end
      end
      return w;
   endfunction

   // one flood step: neighbors of the reached nodes, kept inside the set
   function automatic node_mask_type grow_step(node_mask_type reach, node_mask_type set);
      node_mask_type g;
      g = reach;
      for (int n = 0; n < NODE_COUNT; n++) begin
         if (reach[n]) begin
            g = g | ADJ_MASK[n];
         end
      end
      return g & set;
   endfunction

   // lowest set bit, the seed of a flood fill
   function automatic node_mask_type lowest_bit(node_mask_type m);
      return m & (~m + node_mask_type'(1));
   endfunction

endpackage

`default_nettype wire

// File: sv/thick_slice_simple_point_check_top.sv
// ----------------------------------------------------------------------------
// thick_slice_simple_point_check_top
// Simple-point test on a 17-node thick-slice neighborhood: widen the mask,
// then flood-fill the set and its complement through a chain of cells.
//
//   channel | ports                                | direction
//   req     | req_valid req_stall req_neighbour_mask | in
//   rsp     | rsp_valid rsp_stall rsp_topology_change rsp_cause | out
//
// One beat enters per cycle while req_stall is low; a beat passes 2 widening stages,
// 17 flood cells and 1 result register.
// The whole pipeline moves together: it holds only while a result waits
// with rsp_stall high, and req_stall is raised in exactly those cycles.
// Synchronous reset clears all valid flags; nothing else needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_slice_simple_point_check_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire tsspc_pkg::node_mask_type req_neighbour_mask,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_topology_change,
   output tsspc_pkg::cause_type          rsp_cause
);
   import tsspc_pkg::*;

   logic      advance;
   beat_type  chain [STEP_COUNT+1];
   beat_type  last_beat;
   cause_type cause_in;
   logic      rsp_valid_ff;
   cause_type rsp_cause_ff;

   // pipeline moves unless a result is held
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   tsspc_widen u_widen (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_mask  (req_neighbour_mask),
      .out_beat (chain[0])
   );

   // flood-fill cell chain
   for (genvar i = 0; i < STEP_COUNT; i++) begin : g_cell
      tsspc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .beat_i  (chain[i]),
         .beat_o  (chain[i+1])
      );
   end

   assign last_beat = chain[STEP_COUNT];

   // judge: set first, complement second, first failure wins
   always_comb begin
      if (last_beat.set == '0) begin
         cause_in = CAUSE_EMPTY_SET;
      end else if (last_beat.reach_set != last_beat.set) begin
         cause_in = CAUSE_SPLIT_SET;
      end else if (last_beat.compl_set == '0) begin
         cause_in = CAUSE_EMPTY_COMPL;
      end else if (last_beat.reach_compl != last_beat.compl_set) begin
         cause_in = CAUSE_SPLIT_COMPL;
      end else begin
         cause_in = CAUSE_NONE;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_cause_ff <= cause_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cause           = rsp_cause_ff;
   assign rsp_topology_change = (rsp_cause_ff != CAUSE_NONE);

endmodule

`default_nettype wire

// File: sv/tsspc_widen.sv
// ----------------------------------------------------------------------------
// tsspc_widen
// Two-stage front end: applies the widening rules, then builds the set,
// its complement and the flood seeds of both.
// ----------------------------------------------------------------------------
`default_nettype none

module tsspc_widen (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire tsspc_pkg::node_mask_type in_mask,
   output tsspc_pkg::beat_type           out_beat
);
   import tsspc_pkg::*;

   logic          valid_a_ff, valid_a_in;
   node_mask_type mask_a_ff, mask_a_in;
   beat_type      beat_ff, beat_in;
   node_mask_type wide_mask;
   node_mask_type compl_mask;

   // first stage: early rules
   always_comb begin
      valid_a_in = in_valid;
      mask_a_in  = widen_rules(in_mask & ALL_NODES, 0, RULE_SPLIT - 1);
   end

   // second stage: late rules, complement and seeds
   always_comb begin
      wide_mask           = widen_rules(mask_a_ff, RULE_SPLIT, RULE_COUNT - 1) & ALL_NODES;
      compl_mask          = ~wide_mask & ALL_NODES;
      beat_in.valid       = valid_a_ff;
      beat_in.set         = wide_mask;
      beat_in.compl_set   = compl_mask;
      beat_in.reach_set   = lowest_bit(wide_mask);
      beat_in.reach_compl = lowest_bit(compl_mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         beat_ff    <= '0;
      end else if (advance) begin
         valid_a_ff <= valid_a_in;
         beat_ff    <= beat_in;
      end
   end

   // mask payload carries no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         mask_a_ff <= mask_a_in;
      end
   end

   assign out_beat = beat_ff;

endmodule

`default_nettype wire

// File: sv/tsspc_cell.sv
// ----------------------------------------------------------------------------
// tsspc_cell
// One flood-fill cell: grows the reached region of the set and of its
// complement by one step and hands the beat to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tsspc_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire tsspc_pkg::beat_type beat_i,
   output tsspc_pkg::beat_type      beat_o
);
   import tsspc_pkg::*;

   beat_type beat_ff, beat_in;

   // one growth step on both floods
   always_comb begin
      beat_in             = beat_i;
      beat_in.reach_set   = grow_step(beat_i.reach_set, beat_i.set);
      beat_in.reach_compl = grow_step(beat_i.reach_compl, beat_i.compl_set);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

`default_nettype wire

// File: sv/thick_slice_simple_point_check_checker.sv
// ----------------------------------------------------------------------------
// thick_slice_simple_point_check_checker
// Port-level checks for the simple-point block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_slice_simple_point_check_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire tsspc_pkg::node_mask_type req_neighbour_mask,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_topology_change,
   input wire tsspc_pkg::cause_type     rsp_cause
);
   import tsspc_pkg::*;

   // no result beat right after reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // a held result keeps its beat
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cause))
      else $error("held result beat changed");

   // change flag agrees with the cause
   a_flag_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_topology_change == (rsp_cause != CAUSE_NONE))
      else $error("topology flag disagrees with cause");

   // input is held back only behind a blocked result
   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side is free");

   // a stalled mask beat stays in place
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_neighbour_mask))
      else $error("stalled mask beat changed");

endmodule

bind thick_slice_simple_point_check_top thick_slice_simple_point_check_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_neighbour_mask  (req_neighbour_mask),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_topology_change (rsp_topology_change),
   .rsp_cause           (rsp_cause)
);

`default_nettype wire

// File: test/tsspc_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsspc_point_checker
// Watches the mask and verdict channels of the thick-slice simple-point
// check. Every accepted mask gets a predicted verdict from an independent
// copy of the widening rules and the flood fill. Each accepted verdict is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tsspc_point_checker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire tsspc_pkg::node_mask_type req_neighbour_mask,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic                     rsp_topology_change,
   input  wire tsspc_pkg::cause_type     rsp_cause,
   output int                            fail_count,
   output int                            pending_count,
   output int                            masks_seen,
   output int                            changes_seen,
   output logic [4:0]                    causes_seen
);
   import tsspc_pkg::*;

   typedef enum logic [1:0] {
      COMP_CONNECTED,
      COMP_EMPTY,
      COMP_SPLIT
   } component_verdict_type;

   typedef struct packed {
      logic      change;
      cause_type cause;
   } point_verdict_type;

   // graph links: 4-adjacency in each layer plus ring-to-grid twins
   localparam node_mask_type NODE_LINKS [NODE_COUNT] = '{
      17'h0010A, 17'h00205, 17'h00412, 17'h00821, 17'h02084, 17'h04048,
      17'h080A0, 17'h10050, 17'h00A01, 17'h01502, 17'h02204, 17'h05108,
      17'h0AA00, 17'h11410, 17'h08820, 17'h15040, 17'h0A080
   };

   // widening rules in order of application: trigger node and bits it adds
   localparam int WIDEN_TRIGGER_NODE [13] = '{
      1, 3, 4, 6, 12, 0, 2, 5, 7, 9, 11, 13, 15
   };
   localparam node_mask_type WIDEN_ADD_MASK [13] = '{
      17'h00205, 17'h00821, 17'h02084, 17'h080A0, 17'h0AA00, 17'h00100,
      17'h00400, 17'h04000, 17'h10000, 17'h00500, 17'h04100, 17'h10400,
      17'h14000
   };

   point_verdict_type expected_verdicts [$];
   int                mismatches = 0;

   // each rule sees the bits added by the rules before it
   function automatic node_mask_type widen_mask(node_mask_type m);
      for (int r = 0; r < 13; r++) begin
         if (m[WIDEN_TRIGGER_NODE[r]]) begin
            m = m | WIDEN_ADD_MASK[r];
         end
      end
      return m;
   endfunction

   // flood fill from the lowest member, one graph step per pass
   function automatic component_verdict_type judge_component(node_mask_type members);
      node_mask_type reach;
      node_mask_type grow;
      if (members == '0) begin
         return COMP_EMPTY;
      end
      reach = members & (~members + node_mask_type'(1));
      repeat (NODE_COUNT) begin
         grow = reach;
         for (int n = 0; n < NODE_COUNT; n++) begin
            if (reach[n]) begin
               grow = grow | NODE_LINKS[n];
            end
         end
         reach = grow & members;
      end
      return (reach == members) ? COMP_CONNECTED : COMP_SPLIT;
   endfunction

   // set first, then its complement; first failing test names the cause
   function automatic point_verdict_type predict_simple_point(node_mask_type mask);
      node_mask_type         widened;
      point_verdict_type     verdict;
      component_verdict_type comp;
      widened = widen_mask(mask);
      comp    = judge_component(widened);
      case (comp)
         COMP_EMPTY: verdict.cause = CAUSE_EMPTY_SET;
         COMP_SPLIT: verdict.cause = CAUSE_SPLIT_SET;
         default: begin
            case (judge_component(~widened))
               COMP_EMPTY: verdict.cause = CAUSE_EMPTY_COMPL;
               COMP_SPLIT: verdict.cause = CAUSE_SPLIT_COMPL;
               default:    verdict.cause = CAUSE_NONE;
            endcase
         end
      endcase
      verdict.change = (verdict.cause != CAUSE_NONE);
      return verdict;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] verdict mismatch: %s", $realtime, what);
   endtask

   // predict on every mask beat, compare on every verdict beat
   always @(posedge clock) begin
      point_verdict_type want;
      if (reset) begin
         expected_verdicts.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_verdicts.push_back(predict_simple_point(req_neighbour_mask));
            masks_seen <= masks_seen + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, change %0b cause %0d",
                                         rsp_topology_change, rsp_cause));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_topology_change !== want.change) begin
                  report_mismatch($sformatf("topology_change %0b, expected %0b",
                                            rsp_topology_change, want.change));
               end
               if (rsp_cause !== want.cause) begin
                  report_mismatch($sformatf("cause %0d, expected %0d",
                                            rsp_cause, want.cause));
               end
               if (want.change) begin
                  changes_seen <= changes_seen + 1;
               end
               causes_seen[want.cause] <= 1'b1;
            end
         end
      end
      pending_count <= expected_verdicts.size();
      fail_count    <= mismatches;
   end

   initial begin
      fail_count    = 0;
      pending_count = 0;
      masks_seen    = 0;
      changes_seen  = 0;
      causes_seen   = '0;
   end

endmodule

// File: test/thick_slice_simple_point_check_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_slice_simple_point_check_top_tb
// Drives neighbourhood masks into the simple-point check: a directed set of
// corner masks, then random masks of mixed density, with random idle and
// stall bursts on both channels. A checker beside the block predicts and
// compares every verdict; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module thick_slice_simple_point_check_top_tb;
   import tsspc_pkg::*;

   localparam int RANDOM_MASKS   = 1750;
   localparam int QUIET_TAIL     = 250;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   node_mask_type req_neighbour_mask = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_topology_change;
   cause_type     rsp_cause;

   int            idle_pct = 20;
   int            stall_left = 0;
   int            quiet_cycles = 0;
   int            fail_count;
   int            pending_count;
   int            masks_seen;
   int            changes_seen;
   logic [4:0]    causes_seen;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   thick_slice_simple_point_check_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_neighbour_mask  (req_neighbour_mask),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_topology_change (rsp_topology_change),
      .rsp_cause           (rsp_cause)
   );

   tsspc_point_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_neighbour_mask  (req_neighbour_mask),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_topology_change (rsp_topology_change),
      .rsp_cause           (rsp_cause),
      .fail_count          (fail_count),
      .pending_count       (pending_count),
      .masks_seen          (masks_seen),
      .changes_seen        (changes_seen),
      .causes_seen         (causes_seen)
   );

   // verdict-side stall bursts, started at random at the idle rate
   always @(posedge clock) begin
      if (reset || idle_pct == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 15);
      end
   end

   // end the run when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("thick_slice_simple_point_check_top_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one mask beat, with a random idle burst ahead of it
   task automatic send_mask(input node_mask_type m);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_neighbour_mask <= m;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // density varies from near-empty to near-full
   function automatic node_mask_type random_mask();
      node_mask_type m;
      int            thin;
      m    = node_mask_type'($urandom);
      thin = $urandom_range(0, 4);
      repeat (thin) m = m & node_mask_type'($urandom);
      if ($urandom_range(9) == 0) begin
         m = m | ~node_mask_type'($urandom & $urandom);
      end
      return m;
   endfunction

   initial begin
      node_mask_type directed_masks [$];
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty, full, each node alone, split columns, checkerboards
      directed_masks.push_back('0);
      directed_masks.push_back(ALL_NODES);
      for (int k = 0; k < NODE_COUNT; k++) begin
         directed_masks.push_back(node_mask_type'(1) << k);
      end
      directed_masks.push_back(17'h00500);
      directed_masks.push_back(17'h02818);
      directed_masks.push_back(17'h15555);
      directed_masks.push_back(17'h0AAAA);
      foreach (directed_masks[i]) begin
         send_mask(directed_masks[i]);
      end

      // random phases with changing idle rate, none at the end
      for (int i = 0; i < RANDOM_MASKS; i++) begin
         if (i >= RANDOM_MASKS - QUIET_TAIL) begin
            idle_pct <= 0;
         end else if (i % 125 == 0) begin
            case ($urandom_range(3))
               0:       idle_pct <= 0;
               1:       idle_pct <= 5;
               2:       idle_pct <= 20;
               default: idle_pct <= 50;
            endcase
         end
         send_mask(random_mask());
      end
      req_valid <= 1'b0;

      // drain outstanding verdicts, then a short tail
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d neighbourhood masks, %0d flagged as topology changes",
               masks_seen, changes_seen);
      $display("cause codes reached (bits 4..0 = split compl..none): %b", causes_seen);
      if (fail_count == 0) begin
         $display("thick_slice_simple_point_check_top_tb: PASS");
      end else begin
         $display("thick_slice_simple_point_check_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: thick_slice_simple_point_check_top.f
sv/tsspc_pkg.sv
sv/tsspc_widen.sv
sv/tsspc_cell.sv
sv/thick_slice_simple_point_check_top.sv
sv/thick_slice_simple_point_check_checker.sv
test/tsspc_point_checker.sv
test/thick_slice_simple_point_check_top_tb.sv
